// ===== rtl/mfa_pkg.sv =====
package mfa_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_MUL = 2'd1,
      OP_INV = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_DISPATCH,
      ST_MUL,
      ST_INV_DIV,
      ST_INV_STEP,
      ST_INV_END,
      ST_MUL2,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture request word, start reduction of a
      logic red_b_start; // start reduction of b
      logic add;         // form modular sum into result
      logic mul_start;   // start shift-and-add multiply result = a*b
      logic inv_init;    // set up Euclid on the selected operand
      logic div_start;   // start remainder division r0 / r1
      logic inv_update;  // rotate remainders, start t update multiply
      logic inv_finish;  // check gcd, write result or error
      logic mul2_start;  // result = a * inverse
      logic clear_res;   // result = 0, flag = 0
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic busy;     // the shared iterative unit is still working
      logic r1_zero;  // Euclid remainder reached zero
      logic x_zero;   // operand to invert is zero
      logic bad;      // gcd was not one
   } status_type;

endpackage

// ===== rtl/mfa_if.sv =====
interface mfa_req_if #(parameter int WIDTH = 32);
   logic               valid;
   logic               ready;
   mfa_pkg::op_type    op;
   logic [WIDTH-1:0]   operand_a;
   logic [WIDTH-1:0]   operand_b;
   modport source (output valid, op, operand_a, operand_b, input ready);
   modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

interface mfa_rsp_if #(parameter int WIDTH = 32);
   logic               valid;
   logic               ready;
   logic [WIDTH-1:0]   result;
   logic               not_invertible;
   modport source (output valid, result, not_invertible, input ready);
   modport sink   (input valid, result, not_invertible, output ready);
endinterface

interface mfa_csr_if #(parameter int WIDTH = 32);
   logic               valid;
   logic               ready;
   logic [WIDTH-1:0]   data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/mfa_ctrl.sv =====
module mfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mfa_pkg::op_type      req_op,
   output logic                 done,
   input  logic                 rsp_taken,
   input  mfa_pkg::status_type  status,
   output mfa_pkg::cmd_type     cmd
);

   mfa_pkg::state_type state_ff, state_in;
   mfa_pkg::op_type    op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfa_pkg::ST_IDLE;
         op_ff    <= mfa_pkg::OP_ADD;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         mfa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = mfa_pkg::ST_RED_A;
               op_in    = req_op;
            end
         end
         mfa_pkg::ST_RED_A: begin
            if (!status.busy) state_in = mfa_pkg::ST_RED_B;
         end
         mfa_pkg::ST_RED_B: begin
            if (!status.busy) state_in = mfa_pkg::ST_DISPATCH;
         end
         mfa_pkg::ST_DISPATCH: begin
            case (op_ff)
               mfa_pkg::OP_ADD: state_in = mfa_pkg::ST_DONE;
               mfa_pkg::OP_MUL: state_in = mfa_pkg::ST_MUL;
               default: state_in = mfa_pkg::ST_INV_DIV;
            endcase
         end
         mfa_pkg::ST_MUL, mfa_pkg::ST_MUL2: begin
            if (!status.busy) state_in = mfa_pkg::ST_DONE;
         end
         mfa_pkg::ST_INV_DIV: begin
            if (status.x_zero || status.r1_zero) state_in = mfa_pkg::ST_INV_END;
            else if (!status.busy) state_in = mfa_pkg::ST_INV_STEP;
         end
         mfa_pkg::ST_INV_STEP: begin
            if (!status.busy) state_in = mfa_pkg::ST_INV_DIV;
         end
         mfa_pkg::ST_INV_END: begin
            if (op_ff == mfa_pkg::OP_DIV && !status.x_zero && !status.bad)
               state_in = mfa_pkg::ST_MUL2;
            else
               state_in = mfa_pkg::ST_DONE;
         end
         mfa_pkg::ST_DONE: begin
            if (rsp_taken) state_in = mfa_pkg::ST_IDLE;
         end
         default: state_in = mfa_pkg::ST_IDLE;
      endcase
   end

   // Busy reflects a start command from the following cycle on, so each start is
   // issued on the cycle that enters the waiting state.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      done      = 1'b0;
      case (state_ff)
         mfa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         mfa_pkg::ST_RED_A: cmd.red_b_start = !status.busy;
         mfa_pkg::ST_DISPATCH: begin
            case (op_ff)
               mfa_pkg::OP_ADD: cmd.add = 1'b1;
               mfa_pkg::OP_MUL: cmd.mul_start = 1'b1;
               default: cmd.inv_init = 1'b1;
            endcase
         end
         mfa_pkg::ST_INV_DIV: begin
            if (!status.x_zero && !status.r1_zero && !status.busy)
               cmd.inv_update = 1'b1;
         end
         mfa_pkg::ST_INV_STEP: cmd.div_start = !status.busy;
         mfa_pkg::ST_INV_END: begin
            cmd.inv_finish = 1'b1;
            cmd.mul2_start = op_ff == mfa_pkg::OP_DIV && !status.x_zero
                             && !status.bad;
         end
         mfa_pkg::ST_DONE: done = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== rtl/mfa_datapath.sv =====
module mfa_datapath #(
   parameter int WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [WIDTH-1:0]     modulus,
   input  logic [WIDTH-1:0]     in_a,
   input  logic [WIDTH-1:0]     in_b,
   input  mfa_pkg::op_type      in_op,
   input  mfa_pkg::cmd_type     cmd,
   output mfa_pkg::status_type  status,
   output logic [WIDTH-1:0]     result,
   output logic                 not_invertible
);

   localparam int CW = $clog2(WIDTH + 1);

   // Shared iterative unit modes.
   typedef enum logic [1:0] {
      U_IDLE, U_DIV, U_MUL
   } umode_type;

   logic [WIDTH-1:0] m;
   assign m = (modulus == '0) ? {{(WIDTH-1){1'b0}}, 1'b1} : modulus;

   logic [WIDTH-1:0] a_ff, a_in, b_ff, b_in;
   logic [WIDTH-1:0] r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic             bad_ff, bad_in, xz_ff, xz_in;
   mfa_pkg::op_type  op_ff, op_in;

   // Restoring divider state: remainder, quotient, dividend shifter.
   umode_type        mode_ff, mode_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH:0]   rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in, dvd_ff, dvd_in, dsr_ff, dsr_in;
   // Multiplier state: accumulator, multiplicand, multiplier bits.
   logic [WIDTH-1:0] acc_ff, acc_in, mx_ff, mx_in, my_ff, my_in;
   logic [1:0]       dest_ff, dest_in; // 0 a, 1 b, 2 t update, 3 result

   localparam logic [1:0] D_A = 2'd0, D_B = 2'd1, D_T = 2'd2, D_RES = 2'd3;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= U_IDLE;
         cnt_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in; b_ff <= b_in; r0_ff <= r0_in; r1_ff <= r1_in;
      t0_ff <= t0_in; t1_ff <= t1_in; res_ff <= res_in; bad_ff <= bad_in;
      xz_ff <= xz_in; op_ff <= op_in; rem_ff <= rem_in; quo_ff <= quo_in;
      dvd_ff <= dvd_in; dsr_ff <= dsr_in; acc_ff <= acc_in; mx_ff <= mx_in;
      my_ff <= my_in; dest_ff <= dest_in;
   end

   function automatic logic [WIDTH-1:0] addm(input logic [WIDTH-1:0] x,
      input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] md);
      logic [WIDTH:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, md}) s = s - {1'b0, md};
      return s[WIDTH-1:0];
   endfunction

   function automatic logic [WIDTH-1:0] subm(input logic [WIDTH-1:0] x,
      input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] md);
      return (x >= y) ? x - y : x + (md - y);
   endfunction

   logic [WIDTH:0] trial;
   logic [WIDTH:0] shifted;

   always_comb begin
      a_in = a_ff; b_in = b_ff; r0_in = r0_ff; r1_in = r1_ff;
      t0_in = t0_ff; t1_in = t1_ff; res_in = res_ff; bad_in = bad_ff;
      xz_in = xz_ff; op_in = op_ff; mode_in = mode_ff; cnt_in = cnt_ff;
      rem_in = rem_ff; quo_in = quo_ff; dvd_in = dvd_ff; dsr_in = dsr_ff;
      acc_in = acc_ff; mx_in = mx_ff; my_in = my_ff; dest_in = dest_ff;
      shifted = {rem_ff[WIDTH-1:0], dvd_ff[WIDTH-1]};
      trial   = shifted - {1'b0, dsr_ff};

      // Iteration of the shared unit, one bit per cycle.
      case (mode_ff)
         U_DIV: begin
            if (!trial[WIDTH]) begin
               rem_in = trial;
               quo_in = {quo_ff[WIDTH-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[WIDTH-2:0], 1'b0};
            end
            dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               mode_in = U_IDLE;
               if (dest_ff == D_A) a_in = rem_in[WIDTH-1:0];
               if (dest_ff == D_B) b_in = rem_in[WIDTH-1:0];
            end
         end
         U_MUL: begin
            if (my_ff == '0) begin
               mode_in = U_IDLE;
               if (dest_ff == D_T) begin
                  t1_in = subm(t0_ff, acc_ff, m);
                  t0_in = t1_ff;
               end else begin
                  res_in = acc_ff;
               end
            end else begin
               if (my_ff[0]) acc_in = addm(acc_ff, mx_ff, m);
               mx_in = addm(mx_ff, mx_ff, m);
               my_in = my_ff >> 1;
            end
         end
         default: mode_in = U_IDLE;
      endcase

      if (cmd.load) begin
         a_in = in_a; b_in = in_b; op_in = in_op;
         bad_in = 1'b0; xz_in = 1'b0; res_in = '0;
         mode_in = U_DIV; cnt_in = CW'(WIDTH); rem_in = '0;
         dvd_in = in_a; dsr_in = m; dest_in = D_A;
      end
      if (cmd.red_b_start) begin
         mode_in = U_DIV; cnt_in = CW'(WIDTH); rem_in = '0;
         dvd_in = b_ff; dsr_in = m; dest_in = D_B;
      end
      if (cmd.add) res_in = addm(a_ff, b_ff, m);
      if (cmd.mul_start || cmd.mul2_start) begin
         mode_in = U_MUL; acc_in = '0; dest_in = D_RES;
         mx_in = a_ff;
         my_in = cmd.mul2_start ? t0_ff : b_ff;
      end
      if (cmd.inv_init) begin
         r0_in = m;
         r1_in = (op_ff == mfa_pkg::OP_INV) ? a_ff : b_ff;
         xz_in = r1_in == '0;
         t0_in = '0;
         t1_in = (m == {{(WIDTH-1){1'b0}}, 1'b1}) ? '0 : {{(WIDTH-1){1'b0}}, 1'b1};
         mode_in = U_DIV; cnt_in = CW'(WIDTH); rem_in = '0;
         dvd_in = m; dsr_in = r1_in; dest_in = D_T;
      end
      if (cmd.div_start) begin
         mode_in = U_DIV; cnt_in = CW'(WIDTH); rem_in = '0;
         dvd_in = r0_ff; dsr_in = r1_ff; dest_in = D_T;
      end
      // Quotient is below m except for the first step, where r0 = m and
      // r1 = 1 gives q = m, which is zero modulo m.
      if (cmd.inv_update) begin
         r0_in = r1_ff;
         r1_in = rem_ff[WIDTH-1:0];
         mode_in = U_MUL; acc_in = '0; dest_in = D_T;
         mx_in = (quo_ff >= m) ? '0 : quo_ff;
         my_in = t1_ff;
      end
      if (cmd.inv_finish) begin
         bad_in = !xz_ff && r0_ff != {{(WIDTH-1){1'b0}}, 1'b1};
         res_in = (op_ff == mfa_pkg::OP_INV && !xz_ff && !bad_in) ? t0_ff : '0;
      end
      if (cmd.clear_res) begin
         res_in = '0; bad_in = 1'b0;
      end
   end

   assign status.busy    = mode_ff != U_IDLE;
   assign status.r1_zero = r1_ff == '0;
   assign status.x_zero  = xz_ff;
   assign status.bad     = !xz_ff && r0_ff != {{(WIDTH-1){1'b0}}, 1'b1};
   assign result         = res_ff;
   assign not_invertible = bad_ff;

endmodule

// ===== rtl/modular_field_arithmetic.sv =====
// Channel  Ports  Direction  Moves
// -------  -----  ---------  ------------------------------------------
// request  req_   in         op, operand_a, operand_b
// response rsp_   out        result, not_invertible
// config   csr_   in         modulus write data
//
// An item runs the two reductions, plus a shift-and-add for a multiply. An
// inverse spends one division and one shift-and-add per Euclid step over at
// most about 1.5*WIDTH steps, and a divide adds one final multiply; the
// shared bit-serial divide and multiply unit serves one word at a time.
// Reset is synchronous and active high; the modulus resets to one.
// A finished word waits in the result registers while rsp_ready is low;
// no new request word is taken until it has been delivered.
module modular_field_arithmetic #(
   parameter int WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   mfa_req_if.sink   req,
   mfa_rsp_if.source rsp,
   mfa_csr_if.sink   csr
);

   mfa_pkg::cmd_type    cmd;
   mfa_pkg::status_type status;
   logic                done;
   logic [WIDTH-1:0]    modulus_ff;

   // Modulus always ready; writes must come only while idle, unenforced.
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= {{(WIDTH-1){1'b0}}, 1'b1};
      end else if (csr.valid) begin
         modulus_ff <= csr.data;
      end
   end

   mfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_op    (req.op),
      .done      (done),
      .rsp_taken (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mfa_datapath #(.WIDTH(WIDTH)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .modulus        (modulus_ff),
      .in_a           (req.operand_a),
      .in_b           (req.operand_b),
      .in_op          (req.op),
      .cmd            (cmd),
      .status         (status),
      .result         (rsp.result),
      .not_invertible (rsp.not_invertible)
   );

   assign rsp.valid = done;

`ifndef SYNTHESIS
   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request taken while a response is pending");
   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && modulus_ff > {{(WIDTH-1){1'b0}}, 1'b1} |-> rsp.result < modulus_ff)
      else $error("result not reduced");
   a_flag_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.not_invertible |-> rsp.result == '0)
      else $error("error flag with nonzero result");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench;

   localparam int WIDTH       = 32;
   localparam int IDLE_CYCLES = 20;     // settle time before a modulus write
   localparam int STALL_LIMIT = 200000; // cycles with no accepted word before giving up
   localparam int NUM_RANDOM  = 900;

   // One row of the directed table. When has_exp is set, the expected word was
   // worked out by hand and is checked against the predictor as well.
   typedef struct {
      logic                 set_mod;
      logic [31:0]          modulus;
      mfa_pkg::op_type      op;
      logic [31:0]          a;
      logic [31:0]          b;
      logic                 has_exp;
      logic [31:0]          exp_result;
      logic                 exp_flag;
   } vector_type;

   typedef struct {
      logic [31:0] result;
      logic        flag;
   } residue_type;

   logic clock;
   logic reset;

   mfa_req_if #(.WIDTH(WIDTH)) req ();
   mfa_rsp_if #(.WIDTH(WIDTH)) rsp ();
   mfa_csr_if #(.WIDTH(WIDTH)) csr ();

   modular_field_arithmetic #(.WIDTH(WIDTH)) uut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   // The predictor keeps its own copy of the modulus.
   logic [31:0] field_modulus;
   residue_type pending_residues[$];
   int          mismatches;
   int          words_sent;
   int          words_checked;
   int          idle_count;
   int          op_count[4];
   int          flag_count;
   logic        hold_off;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Exact modular product: the 64-bit product of two 32-bit residues cannot wrap.
   function automatic logic [31:0] mod_product(logic [31:0] x, logic [31:0] y,
                                               logic [31:0] m);
      logic [63:0] p;
      p = 64'(x) * 64'(y);
      return 32'(p % 64'(m));
   endfunction

   // Extended Euclid on x modulo m. Sets bad when the gcd is not one; a zero x gives zero without bad.
   function automatic logic [31:0] mod_inverse(logic [31:0] x, logic [31:0] m,
                                               output logic bad);
      longint r0, r1, r2, t0, t1, t2, q;
      bad = 1'b0;
      if (x == 0) return 32'd0;
      r0 = m; r1 = x; t0 = 0; t1 = 1;
      while (r1 != 0) begin
         q  = r0 / r1;
         r2 = r0 - q * r1;
         t2 = t0 - q * t1;
         r0 = r1; r1 = r2; t0 = t1; t1 = t2;
      end
      if (r0 != 1) begin
         bad = 1'b1;
         return 32'd0;
      end
      t0 = t0 % longint'(m);
      if (t0 < 0) t0 = t0 + longint'(m);
      return 32'(t0);
   endfunction

   function automatic residue_type predict_residue(mfa_pkg::op_type op,
                                                   logic [31:0] a_in,
                                                   logic [31:0] b_in);
      residue_type r;
      logic [31:0] m, a, b, inv;
      logic [32:0] s;
      logic        bad;
      m = (field_modulus == 0) ? 32'd1 : field_modulus;
      a = a_in % m;
      b = b_in % m;
      r.flag = 1'b0;
      case (op)
         mfa_pkg::OP_ADD: begin
            s = 33'(a) + 33'(b);
            r.result = 32'(s % 33'(m));
         end
         mfa_pkg::OP_MUL: r.result = mod_product(a, b, m);
         mfa_pkg::OP_INV: begin
            r.result = mod_inverse(a, m, bad);
            r.flag = bad;
         end
         default: begin
            inv = mod_inverse(b, m, bad);
            r.result = bad ? 32'd0 : mod_product(a, inv, m);
            r.flag = bad;
         end
      endcase
      return r;
   endfunction

   // Random gap length: mostly none or short, now and then long.
   function automatic int gap_length();
      int dice;
      dice = $urandom_range(0, 99);
      if (dice < 50) return 0;
      if (dice < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 300);
   endfunction

   // Sends one request word and records what the unit should answer. Valid
   // stays high after the accepting edge so that a following word can go out
   // back to back; a gap or the caller drops it.
   task automatic send_word(mfa_pkg::op_type op, logic [31:0] a, logic [31:0] b);
      int gap;
      gap = gap_length();
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.op        <= op;
      req.operand_a <= a;
      req.operand_b <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pending_residues.push_back(predict_residue(op, a, b));
      op_count[op]++;
      words_sent++;
   endtask

   // Writes the modulus once nothing is outstanding and the unit has settled.
   task automatic write_modulus(logic [31:0] value);
      req.valid <= 1'b0;
      while (pending_residues.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
      csr.valid <= 1'b1;
      csr.data  <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      field_modulus = value;
   endtask

   // Random operand: usually uniform, sometimes near zero or near the modulus.
   function automatic logic [31:0] pick_operand();
      int dice;
      dice = $urandom_range(0, 9);
      if (dice < 6) return $urandom();
      if (dice < 8) return $urandom_range(0, 3);
      return field_modulus - $urandom_range(0, 2);
   endfunction

   // Response side: random stalls, plus one long hold-off requested by stimulus.
   initial begin
      int gap;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp.ready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
         gap = gap_length();
         if (gap != 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
      end
   end

   // Checker: every accepted response word is compared with the oldest prediction.
   always @(posedge clock) begin
      residue_type expected;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_residues.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word: result %h flag %b",
                        rsp.result, rsp.not_invertible);
         end else begin
            expected = pending_residues.pop_front();
            words_checked++;
            if (expected.flag) flag_count++;
            if (rsp.result !== expected.result
                || rsp.not_invertible !== expected.flag) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected result %h flag %b, got result %h flag %b",
                           expected.result, expected.flag, rsp.result,
                           rsp.not_invertible);
            end
         end
      end
   end

   // Watchdog: counts cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= STALL_LIMIT) begin
            $display("watchdog expired with %0d words outstanding",
                     pending_residues.size());
            $display("** modular_field_arithmetic: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      vector_type vectors[$];
      residue_type hand;
      logic [31:0] moduli[8];
      int i, j;

      mismatches = 0; words_sent = 0; words_checked = 0; idle_count = 0;
      flag_count = 0; hold_off = 1'b0;
      foreach (op_count[k]) op_count[k] = 0;
      field_modulus = 32'd1;
      reset = 1'b1;
      req.valid = 1'b0; req.op = mfa_pkg::OP_ADD; req.operand_a = '0; req.operand_b = '0;
      csr.valid = 1'b0; csr.data = '0;

      // Directed table. The first rows run at the reset modulus of one, so
      // every result is zero. Later rows cover modulus zero, the largest
      // modulus, inverse and divide by zero, and residues sharing a factor.
      vectors = '{
         '{0, 0, mfa_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0},
         '{0, 0, mfa_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h1234_5678, 1, 0, 0},
         '{0, 0, mfa_pkg::OP_INV, 32'd5, 0, 1, 0, 0},
         '{0, 0, mfa_pkg::OP_DIV, 32'd5, 32'd7, 1, 0, 0},
         '{1, 0, mfa_pkg::OP_ADD, 32'd9, 32'd4, 1, 0, 0},
         '{0, 0, mfa_pkg::OP_INV, 32'd9, 0, 1, 0, 0},
         '{1, 7, mfa_pkg::OP_ADD, 32'd6, 32'd6, 1, 5, 0},
         '{0, 0, mfa_pkg::OP_MUL, 32'd3, 32'd5, 1, 1, 0},
         '{0, 0, mfa_pkg::OP_INV, 32'd3, 0, 1, 5, 0},
         '{0, 0, mfa_pkg::OP_INV, 32'd14, 0, 1, 0, 0},
         '{0, 0, mfa_pkg::OP_DIV, 32'd4, 32'd7, 1, 0, 0},
         '{0, 0, mfa_pkg::OP_DIV, 32'd4, 32'd2, 1, 2, 0},
         '{1, 12, mfa_pkg::OP_INV, 32'd8, 0, 1, 0, 1},
         '{0, 0, mfa_pkg::OP_DIV, 32'd5, 32'd6, 1, 0, 1},
         '{0, 0, mfa_pkg::OP_INV, 32'd5, 0, 1, 5, 0},
         '{0, 0, mfa_pkg::OP_INV, 32'd11, 0, 1, 11, 0},
         '{1, 32'hFFFF_FFFF, mfa_pkg::OP_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1,
           32'hFFFF_FFFD, 0},
         '{0, 0, mfa_pkg::OP_ADD, 32'hFFFF_FFFF, 32'd3, 1, 3, 0},
         '{0, 0, mfa_pkg::OP_MUL, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 0, 0, 0},
         '{0, 0, mfa_pkg::OP_INV, 32'd3, 0, 1, 0, 1},
         '{0, 0, mfa_pkg::OP_INV, 32'hFFFF_FFFE, 0, 0, 0, 0},
         '{0, 0, mfa_pkg::OP_DIV, 32'hFFFF_FFFE, 32'hAAAA_5555, 0, 0, 0},
         '{1, 32'hFFFF_FFFB, mfa_pkg::OP_INV, 32'h8000_0000, 0, 0, 0, 0},
         '{0, 0, mfa_pkg::OP_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFA, 0, 0, 0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[n]) begin
         if (vectors[n].set_mod) write_modulus(vectors[n].modulus);
         if (vectors[n].has_exp) begin
            hand = predict_residue(vectors[n].op, vectors[n].a, vectors[n].b);
            if (hand.result !== vectors[n].exp_result
                || hand.flag !== vectors[n].exp_flag) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("table row %0d disagrees with predictor", n);
            end
         end
         send_word(vectors[n].op, vectors[n].a, vectors[n].b);
      end

      // Random phases over a spread of moduli: primes for field behavior,
      // composites for the not-invertible path, and both extremes.
      moduli = '{32'hFFFF_FFFB, 32'd2, 32'h7FFF_FFFF, 32'd360,
                 32'hFFFF_FFFF, 32'h8000_0000, 32'd65537, 32'd0};
      for (i = 0; i < 8; i++) begin
         write_modulus(i == 7 ? 32'hFFFF_FFFF ^ $urandom() : moduli[i]);
         // Partway through, the receiver stalls for a long stretch.
         if (i == 2) hold_off = 1'b1;
         for (j = 0; j < NUM_RANDOM / 8; j++)
            send_word(mfa_pkg::op_type'($urandom_range(0, 3)), pick_operand(),
                      pick_operand());
      end
      req.valid <= 1'b0;

      while (pending_residues.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("sent %0d words (add %0d, mul %0d, inv %0d, div %0d), checked %0d",
               words_sent, op_count[0], op_count[1], op_count[2], op_count[3],
               words_checked);
      $display("%0d not-invertible results across all modulus settings, %0d mismatches",
               flag_count, mismatches);
      if (mismatches == 0 && pending_residues.size() == 0)
         $display("** modular_field_arithmetic: PASSED **");
      else
         $display("** modular_field_arithmetic: FAILED **");
      $finish;
   end

endmodule
